// ----- rtl/sua_pkg.sv -----
// Package with the operator codes, payload types and queue entry type of the 64-bit ALU.
package sua_pkg;

    localparam int DataWidth = 64;
    localparam int FifoDepthDefault = 4;
    localparam int DivSteps = 64;

    typedef enum logic [3:0] {
        OP_MUL = 4'd0,
        OP_DIV = 4'd1,
        OP_MOD = 4'd2,
        OP_ADD = 4'd3,
        OP_SUB = 4'd4,
        OP_SHL = 4'd5,
        OP_SHR = 4'd6,
        OP_LT  = 4'd7,
        OP_GT  = 4'd8,
        OP_LE  = 4'd9,
        OP_GE  = 4'd10,
        OP_EQ  = 4'd11,
        OP_NE  = 4'd12,
        OP_AND = 4'd13,
        OP_XOR = 4'd14,
        OP_OR  = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_DIV0  = 2'd1,
        ERR_SHIFT = 2'd2
    } err_t;

    typedef struct packed {
        logic [3:0]           mode;
        logic [DataWidth-1:0] a_value;
        logic                 a_unsigned;
        logic [DataWidth-1:0] b_value;
        logic                 b_unsigned;
        logic                 evaluate;
    } req_t;

    typedef struct packed {
        logic [DataWidth-1:0] result_value;
        logic                 result_unsigned;
        logic [1:0]           error_code;
    } rsp_t;

    // Classified request held in the queue between front and back.
    typedef struct packed {
        logic                 use_div;
        logic                 want_rem;
        logic                 neg_q;
        logic                 neg_r;
        logic [DataWidth-1:0] num;
        logic [DataWidth-1:0] den;
        rsp_t                 fixed;
    } work_t;

endpackage

// ----- rtl/signed_unsigned_alu64.sv -----
// Top level of the 64-bit signed/unsigned binary operator unit.
//
// This unit applies one of sixteen C binary operators to two tagged 64-bit
// operands and returns one result per request. The front end takes a request
// every cycle while its register is free or being drained, and computes
// multiply (from three 32x32 partial products), add, subtract, logic, shifts
// and comparisons in a single stage; it also classifies division and
// remainder requests and takes their magnitudes. A queue of QueueDepth
// entries sits between front and back so either side can stall alone. The
// back end holds the output register: non-dividing requests pass through it
// at one per cycle as long as out_ready is high; a division or remainder with
// a live nonzero divisor runs the shared radix-2 restoring divider and holds
// the back end until its result is in the output register.
// Signed division truncates toward zero; a divisor of minus one falls out
// of the magnitude divide naturally.
module signed_unsigned_alu64
    import sua_pkg::*;
#(
    parameter int QueueDepth = FifoDepthDefault
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t in_data,
    input  logic in_valid,
    output logic in_ready,
    output rsp_t out_data,
    output logic out_valid,
    input  logic out_ready
);

    work_t f_wk, q_wk;
    logic  f_valid, f_ready, q_valid, q_ready;

    sua_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_req   (in_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .wk       (f_wk),
        .wk_valid (f_valid),
        .wk_ready (f_ready)
    );

    sua_queue #(.Depth(QueueDepth)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (f_wk),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_data  (q_wk),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    sua_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wk        (q_wk),
        .wk_valid  (q_valid),
        .wk_ready  (q_ready),
        .out_rsp   (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

// ----- rtl/sua_front.sv -----
// Front end: accepts requests and computes everything except division.
module sua_front
    import sua_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  in_req,
    input  logic  in_valid,
    output logic  in_ready,
    output work_t wk,
    output logic  wk_valid,
    input  logic  wk_ready
);

    work_t wk_reg, wk_next;
    logic  vld_reg;
    logic [63:0] a, b, pa, pb, ma, mb;
    logic [127:0] prod;
    logic [5:0] sh;
    logic ru, lt_ab, lt_ba, na, nb;

    // Multiply in three 32x32 partial products; the high-high one only feeds
    // bits above 63.
    logic [63:0] p_ll, p_lh, p_hl;

    always_comb
    begin
        a  = in_req.a_value;
        b  = in_req.b_value;
        ru = in_req.a_unsigned | in_req.b_unsigned;
        pa = ru ? a : {~a[63], a[62:0]};
        pb = ru ? b : {~b[63], b[62:0]};
        lt_ab = pa < pb;
        lt_ba = pb < pa;
        sh = b[5:0];
        na = ~ru & a[63];
        nb = ~ru & b[63];
        ma = na ? (64'd0 - a) : a;
        mb = nb ? (64'd0 - b) : b;
        p_ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
        p_lh = {32'd0, a[31:0]} * {32'd0, b[63:32]};
        p_hl = {32'd0, a[63:32]} * {32'd0, b[31:0]};
        prod = {64'd0, p_ll} + {32'd0, p_lh[31:0], 32'd0} + {32'd0, p_hl[31:0], 32'd0};

        wk_next = '0;
        wk_next.num = ma;
        wk_next.den = mb;
        wk_next.neg_q = na ^ nb;
        wk_next.neg_r = na;
        wk_next.fixed.result_unsigned = ru;
        wk_next.fixed.error_code = ERR_NONE;
        unique case (op_t'(in_req.mode))
            OP_MUL: wk_next.fixed.result_value = prod[63:0];
            OP_ADD: wk_next.fixed.result_value = a + b;
            OP_SUB: wk_next.fixed.result_value = a - b;
            OP_AND: wk_next.fixed.result_value = a & b;
            OP_XOR: wk_next.fixed.result_value = a ^ b;
            OP_OR:  wk_next.fixed.result_value = a | b;
            OP_DIV, OP_MOD:
            begin
                if (in_req.evaluate && b == 64'd0)
                    wk_next.fixed.error_code = ERR_DIV0;
                else if (in_req.evaluate)
                begin
                    wk_next.use_div  = 1'b1;
                    wk_next.want_rem = (op_t'(in_req.mode) == OP_MOD);
                end
            end
            OP_SHL, OP_SHR:
            begin
                wk_next.fixed.result_unsigned = in_req.a_unsigned;
                if (in_req.evaluate && b > 64'd63)
                    wk_next.fixed.error_code = ERR_SHIFT;
                else if (op_t'(in_req.mode) == OP_SHL)
                    wk_next.fixed.result_value = a << sh;
                else if (in_req.a_unsigned)
                    wk_next.fixed.result_value = a >> sh;
                else
                    wk_next.fixed.result_value = $unsigned($signed(a) >>> sh);
            end
            OP_LT: wk_next.fixed.result_value = {63'd0, lt_ab};
            OP_GT: wk_next.fixed.result_value = {63'd0, lt_ba};
            OP_LE: wk_next.fixed.result_value = {63'd0, ~lt_ba};
            OP_GE: wk_next.fixed.result_value = {63'd0, ~lt_ab};
            OP_EQ: wk_next.fixed.result_value = {63'd0, a == b};
            OP_NE: wk_next.fixed.result_value = {63'd0, a != b};
            default: wk_next.fixed.result_value = '0;
        endcase
        if (in_req.mode >= OP_LT && in_req.mode <= OP_NE)
            wk_next.fixed.result_unsigned = 1'b0;
    end

    assign in_ready = ~vld_reg | wk_ready;
    assign wk       = wk_reg;
    assign wk_valid = vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            wk_reg <= wk_next;
    end

endmodule

// ----- rtl/sua_queue.sv -----
// Small request queue decoupling the front end from the back end.
module sua_queue
    import sua_pkg::*;
#(
    parameter int Depth = FifoDepthDefault
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  work_t wr_data,
    input  logic  wr_valid,
    output logic  wr_ready,
    output work_t rd_data,
    output logic  rd_valid,
    input  logic  rd_ready
);

    localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

    work_t mem [Depth];
    logic [Aw-1:0] wp_reg, rp_reg;
    logic [Aw:0]   cnt_reg;
    logic wr_go, rd_go;

    assign wr_ready = cnt_reg != Depth[Aw:0];
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem[rp_reg];
    assign wr_go    = wr_valid & wr_ready;
    assign rd_go    = rd_valid & rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_go)
                wp_reg <= (wp_reg == Aw'(Depth - 1)) ? '0 : wp_reg + 1'b1;
            if (rd_go)
                rp_reg <= (rp_reg == Aw'(Depth - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {{Aw{1'b0}}, wr_go} - {{Aw{1'b0}}, rd_go};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_go)
            mem[wp_reg] <= wr_data;
    end

endmodule

// ----- rtl/sua_back.sv -----
// Back end: radix-2 divider for division requests, then the output register.
module sua_back
    import sua_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  work_t wk,
    input  logic  wk_valid,
    output logic  wk_ready,
    output rsp_t  out_rsp,
    output logic  out_valid,
    input  logic  out_ready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } st_t;

    st_t st_reg, st_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] q_reg, q_next, r_reg, r_next, d_reg;
    logic        rem_reg, nq_reg, nr_reg;
    rsp_t        rsp_reg, rsp_next;
    logic [64:0] trial;
    logic        take, fin;

    assign trial = {r_reg, q_reg[63]} - {1'b0, d_reg};
    assign fin   = cnt_reg == 7'(DivSteps - 1);

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (wk_valid)
                         st_next = wk.use_div ? ST_DIV : ST_OUT;
            ST_DIV:  if (fin)
                         st_next = ST_OUT;
            ST_OUT:  if (out_ready)
                     begin
                         if (wk_valid)
                             st_next = wk.use_div ? ST_DIV : ST_OUT;
                         else
                             st_next = ST_IDLE;
                     end
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        take      = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        rsp_next  = rsp_reg;
        out_valid = 1'b0;
        unique case (st_reg)
            ST_IDLE: take = 1'b1;
            ST_DIV:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (!trial[64])
                begin
                    r_next = trial[63:0];
                    q_next = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    r_next = {r_reg[62:0], q_reg[63]};
                    q_next = {q_reg[62:0], 1'b0};
                end
                if (fin)
                begin
                    if (rem_reg)
                        rsp_next.result_value = nr_reg ? 64'd0 - r_next : r_next;
                    else
                        rsp_next.result_value = nq_reg ? 64'd0 - q_next : q_next;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                take = out_ready;
            end
            default: take = 1'b0;
        endcase
        if (take && wk_valid)
        begin
            rsp_next = wk.fixed;
            cnt_next = '0;
            q_next   = wk.num;
            r_next   = '0;
        end
    end

    assign wk_ready = take;
    assign out_rsp  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        rsp_reg <= rsp_next;
        if (take && wk_valid)
        begin
            d_reg   <= wk.den;
            rem_reg <= wk.want_rem;
            nq_reg  <= wk.neg_q;
            nr_reg  <= wk.neg_r;
        end
    end

endmodule

// ----- tb/tb_signed_unsigned_alu64.sv -----
// Self-checking testbench for the 64-bit signed/unsigned binary operator unit.
`timescale 1ns / 100ps

module tb_signed_unsigned_alu64;
    import sua_pkg::*;

    localparam int StallLimit = 20000;

    logic clk;
    logic rst_n;
    req_t in_data;
    logic in_valid;
    logic in_ready;
    rsp_t out_data;
    logic out_valid;
    logic out_ready;

    signed_unsigned_alu64 u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_data (out_data),
        .out_valid(out_valid),
        .out_ready(out_ready)
    );

    // Requests waiting to be driven, and results predicted for accepted requests.
    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   error_count;
    bit   stimulus_done;
    bit   hold_off;
    int   idle_cycles;
    bit   in_taken;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Signed compare done by flipping the sign bits so an unsigned compare works.
    function automatic bit lt64(logic [63:0] x, logic [63:0] y, bit uns);
        if (!uns)
        begin
            x[63] = ~x[63];
            y[63] = ~y[63];
        end
        return x < y;
    endfunction

    // Computes the result the unit must return for one request, following C
    // semantics for the usual arithmetic conversions at 64 bits.
    function automatic rsp_t alu_result(req_t rq);
        rsp_t        r;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        bit          ru;
        a = rq.a_value;
        b = rq.b_value;
        ru = rq.a_unsigned | rq.b_unsigned;
        r.result_value = '0;
        r.result_unsigned = ru;
        r.error_code = ERR_NONE;
        case (op_t'(rq.mode))
            OP_MUL: r.result_value = a * b;
            OP_ADD: r.result_value = a + b;
            OP_SUB: r.result_value = a - b;
            OP_AND: r.result_value = a & b;
            OP_XOR: r.result_value = a ^ b;
            OP_OR:  r.result_value = a | b;
            OP_DIV, OP_MOD:
            begin
                if (!rq.evaluate)
                    r.result_value = '0;
                else if (b == 0)
                    r.error_code = ERR_DIV0;
                else if (ru)
                    r.result_value = (rq.mode == OP_DIV) ? a / b : a % b;
                else
                begin
                    // Signed case works on magnitudes and fixes the sign after.
                    ma = a[63] ? -a : a;
                    mb = b[63] ? -b : b;
                    if (rq.mode == OP_DIV)
                    begin
                        q = ma / mb;
                        r.result_value = (a[63] != b[63]) ? -q : q;
                    end
                    else
                    begin
                        q = ma % mb;
                        r.result_value = a[63] ? -q : q;
                    end
                end
            end
            OP_SHL, OP_SHR:
            begin
                r.result_unsigned = rq.a_unsigned;
                if (rq.evaluate && b > 63)
                    r.error_code = ERR_SHIFT;
                else if (rq.mode == OP_SHL)
                    r.result_value = a << b[5:0];
                else if (rq.a_unsigned)
                    r.result_value = a >> b[5:0];
                else
                    r.result_value = $signed(a) >>> b[5:0];
            end
            default:
            begin
                r.result_unsigned = 1'b0;
                case (op_t'(rq.mode))
                    OP_LT:   r.result_value = 64'(lt64(a, b, ru));
                    OP_GT:   r.result_value = 64'(lt64(b, a, ru));
                    OP_LE:   r.result_value = 64'(!lt64(b, a, ru));
                    OP_GE:   r.result_value = 64'(!lt64(a, b, ru));
                    OP_EQ:   r.result_value = 64'(a == b);
                    default: r.result_value = 64'(a != b);
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        // Bias toward values that hit edges: small, near sign bit, all ones.
        case ($urandom_range(0, 7))
            0: v = 64'($urandom_range(0, 70));
            1: v = -64'($urandom_range(0, 3));
            2: v = {1'b1, 63'd0} + 64'($urandom_range(0, 2)) - 64'd1;
            3: v = v >> $urandom_range(0, 63);
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_req(op_t op, logic [63:0] a, bit au, logic [63:0] b, bit bu, bit ev);
        req_t rq;
        rq.mode = op;
        rq.a_value = a;
        rq.a_unsigned = au;
        rq.b_value = b;
        rq.b_unsigned = bu;
        rq.evaluate = ev;
        pending_reqs.push_back(rq);
    endtask

    // Fill the request queue: directed corner cases, then random requests.
    initial
    begin
        req_t rq;
        stimulus_done = 1'b0;
        add_req(OP_MUL, '1, 1'b0, '1, 1'b0, 1'b1);
        add_req(OP_DIV, 64'd7, 1'b0, 64'd0, 1'b0, 1'b1);
        add_req(OP_MOD, 64'd7, 1'b1, 64'd0, 1'b0, 1'b1);
        add_req(OP_DIV, 64'd7, 1'b0, 64'd0, 1'b0, 1'b0);
        add_req(OP_DIV, {1'b1, 63'd0}, 1'b0, '1, 1'b0, 1'b1);
        add_req(OP_MOD, {1'b1, 63'd0}, 1'b0, '1, 1'b0, 1'b1);
        add_req(OP_DIV, -64'd7, 1'b0, 64'd2, 1'b0, 1'b1);
        add_req(OP_MOD, -64'd7, 1'b0, 64'd2, 1'b0, 1'b1);
        add_req(OP_DIV, -64'd7, 1'b1, 64'd2, 1'b0, 1'b1);
        add_req(OP_ADD, '1, 1'b0, 64'd1, 1'b1, 1'b1);
        add_req(OP_SUB, 64'd0, 1'b0, 64'd1, 1'b0, 1'b1);
        add_req(OP_SHL, 64'd1, 1'b0, 64'd63, 1'b1, 1'b1);
        add_req(OP_SHL, 64'd1, 1'b0, 64'd64, 1'b1, 1'b1);
        add_req(OP_SHR, '1, 1'b0, '1, 1'b0, 1'b1);
        add_req(OP_SHR, {1'b1, 63'd0}, 1'b0, 64'd70, 1'b0, 1'b0);
        add_req(OP_SHR, {1'b1, 63'd0}, 1'b1, 64'd4, 1'b0, 1'b1);
        add_req(OP_LT, '1, 1'b0, 64'd0, 1'b0, 1'b1);
        add_req(OP_LT, '1, 1'b1, 64'd0, 1'b0, 1'b1);
        add_req(OP_GT, 64'd5, 1'b0, 64'd5, 1'b1, 1'b1);
        add_req(OP_LE, 64'd5, 1'b0, 64'd5, 1'b0, 1'b1);
        add_req(OP_GE, {1'b1, 63'd0}, 1'b0, 64'd1, 1'b0, 1'b1);
        add_req(OP_EQ, '1, 1'b0, '1, 1'b1, 1'b1);
        add_req(OP_NE, '1, 1'b0, 64'd0, 1'b0, 1'b1);
        add_req(OP_AND, '1, 1'b1, 64'h5555_5555_5555_5555, 1'b1, 1'b1);
        add_req(OP_XOR, '1, 1'b0, 64'h5555_5555_5555_5555, 1'b0, 1'b1);
        add_req(OP_OR, 64'd0, 1'b0, '1, 1'b0, 1'b0);
        for (int i = 0; i < 650; i++)
        begin
            rq.mode = 4'($urandom_range(0, 15));
            rq.a_value = rand64();
            rq.a_unsigned = 1'($urandom_range(0, 1));
            rq.b_value = rand64();
            rq.b_unsigned = 1'($urandom_range(0, 1));
            rq.evaluate = ($urandom_range(0, 4) != 0);
            pending_reqs.push_back(rq);
        end
        stimulus_done = 1'b1;
    end

    // Remembers whether the request on the input was taken at the last rising edge.
    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
    end

    // Sender: bursts of random length separated by random gaps. Inputs change
    // on the falling edge; valid is held until the request is taken.
    int burst_left;
    int gap_left;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_taken)
            begin
                // Request still waiting for acceptance; keep it stable.
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                in_data <= pending_reqs.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: its own stall pattern, with one long hold-off that lets the
    // queue fill so the input side has to stall too.
    int hold_count;
    int stall_mode;
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    // Long hold-off once the random part is under way.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            hold_count <= 0;
            hold_off <= 1'b0;
        end
        else
        begin
            hold_count <= hold_count + 1;
            hold_off <= (hold_count >= 400) && (hold_count < 700);
        end
    end

    // Monitor: record accepted requests and check accepted results in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && in_ready)
                expected_rsps.push_back(alu_result(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    error_count <= error_count + 1;
                end
                else
                begin
                    if (out_data.result_value !== expected_rsps[0].result_value
                        || out_data.result_unsigned !== expected_rsps[0].result_unsigned
                        || out_data.error_code !== expected_rsps[0].error_code)
                    begin
                        $display("%0t: mismatch expected val=%h uns=%0d err=%0d",
                                 $time, expected_rsps[0].result_value,
                                 expected_rsps[0].result_unsigned,
                                 expected_rsps[0].error_code);
                        $display("%0t:          actual   val=%h uns=%0d err=%0d",
                                 $time, out_data.result_value,
                                 out_data.result_unsigned, out_data.error_code);
                        error_count <= error_count + 1;
                    end
                    void'(expected_rsps.pop_front());
                end
            end
        end
    end

    // Reset, end of run and watchdog.
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        stall_mode = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (!(stimulus_done && pending_reqs.size() == 0 && !in_valid
                 && expected_rsps.size() == 0) && idle_cycles < StallLimit)
            @(posedge clk);
        if (idle_cycles >= StallLimit)
        begin
            $display("signed_unsigned_alu64 verification failed");
            $finish;
        end
        else
        begin
            // Give any stray extra result time to show up.
            repeat (200) @(posedge clk);
            if (error_count == 0)
                $display("signed_unsigned_alu64 verification clean");
            else
                $display("signed_unsigned_alu64 verification failed");
            $finish;
        end
    end

endmodule
